>>> src/ibhq_pkg.sv
`default_nettype none
package ibhq_pkg;

    localparam int HANDLE_BITS   = 16;
    localparam int PRIORITY_BITS = 32;
    localparam int SLOT_BITS     = 10;
    localparam int HEAP_DEPTH    = 1 << SLOT_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_PUSH   = 2'd0;
    localparam mode_t MODE_POP    = 2'd1;
    localparam mode_t MODE_CHANGE = 2'd2;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ORDER_MAX_FIRST = 2'd0;
    localparam cfg_idx_t CFG_CAPACITY_LIMIT  = 2'd1;

    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0]   handle;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

endpackage
`default_nettype wire

>>> src/ibhq_if.sv
`default_nettype none
interface ibhq_req_if;
    logic                                valid;
    logic                                ready;
    ibhq_pkg::mode_t                     mode;
    logic [ibhq_pkg::HANDLE_BITS-1:0]    handle;
    logic [ibhq_pkg::PRIORITY_BITS-1:0]  priority_req;
    ibhq_pkg::slot_t                     position;

    modport source (output valid, mode, handle, priority_req, position, input ready);
    modport sink   (input valid, mode, handle, priority_req, position, output ready);
endinterface

interface ibhq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [ibhq_pkg::HANDLE_BITS-1:0]    entry_handle;
    logic [ibhq_pkg::PRIORITY_BITS-1:0]  entry_priority;
    ibhq_pkg::slot_t                     slot;
    logic                                ok;
    logic                                last;

    modport source (output valid, kind, entry_handle, entry_priority, slot, ok, last,
                    input ready);
    modport sink   (input valid, kind, entry_handle, entry_priority, slot, ok, last,
                    output ready);
endinterface
`default_nettype wire

>>> src/ibhq_ram.sv
`default_nettype none
module ibhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> src/indexed_binary_heap_queue.sv
// Indexed binary heap queue, one request at a time through a single heap RAM.
// A failed request goes straight to completion; sift-up reads one parent per level,
// sift-down one or two children per level (one RAM read per cycle), then placement
// and completion. A stalled result holds the queue until it is taken.
// A new request is taken only after the last one completes; there is a single RAM port.
// Reset: entry count and output clear, min-first order, capacity limit 1023; heap RAM is not cleared.
`default_nettype none
module indexed_binary_heap_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    ibhq_req_if.sink                      req,
    ibhq_rsp_if.source                    rsp,
    input  wire logic                     cfg_we,
    input  wire ibhq_pkg::cfg_idx_t       cfg_index,
    input  wire logic [ibhq_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import ibhq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_POP_R1, S_POP_R2, S_POP_L, S_CH_RD, S_CH_CMP,
        S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_R2, S_DN_R3, S_DN_CMP,
        S_PLACE, S_DONE
    } state_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    entry_t cur_reg, cur_next;
    entry_t cand_reg, cand_next;
    entry_t best_reg, best_next;
    slot_t  idx_reg, idx_next;
    slot_t  start_reg, start_next;
    slot_t  cidx_reg, cidx_next;
    slot_t  cnt_reg, cnt_next;
    slot_t  cap_reg;
    logic   maxf_reg;
    logic   ok_reg, ok_next;

    logic   out_valid_reg, out_valid_next;
    logic   out_kind_reg, out_kind_next;
    entry_t out_entry_reg, out_entry_next;
    slot_t  out_slot_reg, out_slot_next;
    logic   out_ok_reg, out_ok_next;
    logic   out_last_reg, out_last_next;

    logic   ram_we, ram_re;
    slot_t  ram_waddr, ram_raddr;
    entry_t ram_wdata, ram_rdata;

    logic           out_free;
    logic [SLOT_BITS:0] child_w;
    slot_t          parent_idx;

    function automatic logic better(input logic [PRIORITY_BITS-1:0] a,
                                    input logic [PRIORITY_BITS-1:0] b,
                                    input logic maxf);
        return maxf ? (a > b) : (a < b);
    endfunction

    ibhq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(HEAP_DEPTH)) u_heap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || rsp.ready;
    assign child_w    = {idx_reg, 1'b0};
    assign parent_idx = idx_reg >> 1;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.kind           = out_kind_reg;
    assign rsp.entry_handle   = out_entry_reg.handle;
    assign rsp.entry_priority = out_entry_reg.prio;
    assign rsp.slot           = out_slot_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.last           = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cur_next       = cur_reg;
        cand_next      = cand_reg;
        best_next      = best_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        cidx_next      = cidx_reg;
        cnt_next       = cnt_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_entry_next = out_entry_reg;
        out_slot_next  = out_slot_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = cur_reg;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = req.mode;
                    cur_next   = '{handle: req.handle, prio: req.priority_req};
                    best_next  = '0;
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                    unique case (req.mode)
                        MODE_PUSH:
                        begin
                            if (cnt_reg < cap_reg)
                            begin
                                cnt_next   = cnt_reg + 1'b1;
                                idx_next   = cnt_reg + 1'b1;
                                start_next = cnt_reg + 1'b1;
                                ok_next    = 1'b1;
                                state_next = S_UP_RD;
                            end
                        end
                        MODE_POP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                ok_next    = 1'b1;
                                state_next = S_POP_R1;
                            end
                        end
                        MODE_CHANGE:
                        begin
                            if (req.position != '0 && req.position <= cnt_reg)
                            begin
                                idx_next   = req.position;
                                start_next = req.position;
                                ok_next    = 1'b1;
                                state_next = S_CH_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_POP_R1:
            begin
                ram_re     = 1'b1;
                ram_raddr  = slot_t'(1);
                state_next = S_POP_R2;
            end
            S_POP_R2:
            begin
                best_next  = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = cnt_reg;
                state_next = S_POP_L;
            end
            S_POP_L:
            begin
                cur_next   = ram_rdata;
                cnt_next   = cnt_reg - 1'b1;
                idx_next   = slot_t'(1);
                start_next = slot_t'(1);
                state_next = (cnt_reg == slot_t'(1)) ? S_DONE : S_DN_RD;
            end
            S_CH_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_CH_CMP;
            end
            S_CH_CMP:
            begin
                cur_next.handle = ram_rdata.handle;
                state_next = better(cur_reg.prio, ram_rdata.prio, maxf_reg) ? S_UP_RD : S_DN_RD;
            end
            S_UP_RD:
            begin
                if (parent_idx == '0)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (!better(cur_reg.prio, ram_rdata.prio, maxf_reg))
                begin
                    state_next = S_PLACE;
                end
                else if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = ram_rdata;
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b0;
                    out_entry_next = ram_rdata;
                    out_slot_next  = idx_reg;
                    out_ok_next    = 1'b0;
                    out_last_next  = 1'b0;
                    idx_next       = parent_idx;
                    state_next     = S_UP_RD;
                end
            end
            S_DN_RD:
            begin
                if (child_w > {1'b0, cnt_reg})
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = child_w[SLOT_BITS-1:0];
                    state_next = S_DN_R2;
                end
            end
            S_DN_R2:
            begin
                cand_next = ram_rdata;
                cidx_next = child_w[SLOT_BITS-1:0];
                if (child_w < {1'b0, cnt_reg})
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = child_w[SLOT_BITS-1:0] + 1'b1;
                    state_next = S_DN_R3;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_R3:
            begin
                if (better(ram_rdata.prio, cand_reg.prio, maxf_reg))
                begin
                    cand_next = ram_rdata;
                    cidx_next = cidx_reg + 1'b1;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (!better(cand_reg.prio, cur_reg.prio, maxf_reg))
                begin
                    state_next = S_PLACE;
                end
                else if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = cand_reg;
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b0;
                    out_entry_next = cand_reg;
                    out_slot_next  = idx_reg;
                    out_ok_next    = 1'b0;
                    out_last_next  = 1'b0;
                    idx_next       = cidx_reg;
                    state_next     = S_DN_RD;
                end
            end
            S_PLACE:
            begin
                // a change that leaves the entry in place is written but not reported
                if (mode_reg == MODE_CHANGE && idx_reg == start_reg)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else if (out_free)
                begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b0;
                    out_entry_next = cur_reg;
                    out_slot_next  = idx_reg;
                    out_ok_next    = 1'b0;
                    out_last_next  = 1'b0;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b1;
                    out_entry_next = best_reg;
                    out_slot_next  = '0;
                    out_ok_next    = ok_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            maxf_reg      <= 1'b0;
            cap_reg       <= '1;
            mode_reg      <= MODE_PUSH;
            cur_reg       <= '0;
            cand_reg      <= '0;
            best_reg      <= '0;
            idx_reg       <= '0;
            start_reg     <= '0;
            cidx_reg      <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
            out_entry_reg <= '0;
            out_slot_reg  <= '0;
            out_ok_reg    <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            cur_reg       <= cur_next;
            cand_reg      <= cand_next;
            best_reg      <= best_next;
            idx_reg       <= idx_next;
            start_reg     <= start_next;
            cidx_reg      <= cidx_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_entry_reg <= out_entry_next;
            out_slot_reg  <= out_slot_next;
            out_ok_reg    <= out_ok_next;
            out_last_reg  <= out_last_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ORDER_MAX_FIRST: maxf_reg <= cfg_data[0];
                    CFG_CAPACITY_LIMIT:  cap_reg  <= cfg_data[SLOT_BITS-1:0];
                    default:             ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("heap RAM read and write in the same cycle");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr != '0 && ram_waddr <= cnt_reg))
        else $error("heap write outside live slots");

    a_done_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && out_last_reg && out_kind_reg))
        else $error("completion transaction not presented");

    a_new_req_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");
`endif

endmodule
`default_nettype wire
